### design/mwsm_pkg.sv
// mecanum wheel speed mixer: shared constants
// no dependencies
package mwsm_pkg;

	localparam int IN_W  = 16;
	localparam int OUT_W = 16;
	localparam int CFG_W = 15;
	localparam logic [CFG_W-1:0] MAX_SPEED_RESET = 15'd660;

	// trig core works on unsigned q2.30 magnitudes
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;
	localparam logic [29:0] OCT_SPAN = 30'h2000_0000;

	// horner steps, innermost first; sine has five divides then a final multiply by x
	localparam int NSTEP = 6;
	localparam int SIN_DIV [NSTEP] = '{110, 72, 42, 20, 6, 1};
	localparam int COS_DIV [NSTEP] = '{132, 90, 56, 30, 12, 2};

	// two setup stages, three per horner step, one output stage
	localparam int TRIG_LAT  = 2 + 3 * NSTEP + 1;
	localparam int MIX_LAT   = 4;
	localparam int FRONT_LAT = TRIG_LAT + MIX_LAT;

	localparam int QUOT_W   = 15;
	localparam int BACK_LAT = 1 + QUOT_W;

endpackage

### design/mwsm_fifo.sv
// small register queue used between the pipeline parts
// depends on nothing
module mwsm_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr & ~full;
	assign do_rd = rd & ~empty;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule

### design/mwsm_trig.sv
// pipelined sine / cosine of a turn fraction, taylor series by horner steps
// depends on mwsm_pkg
module mwsm_trig
	import mwsm_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [IN_W-1:0]                  heading,
	output logic signed [TRIG_FRAC_BITS:0]   sin_o,
	output logic signed [TRIG_FRAC_BITS:0]   cos_o
);
	localparam int F  = TRIG_FRAC_BITS;
	localparam int SH = 30 - F;
	localparam logic [31:0] LIM = 32'((64'd1 << F) - 64'd1);

	logic [ANGLE_BITS-1:0] ang;
	logic [31:0] turn;
	logic [2:0]  oct_in;
	logic [29:0] r_in;

	logic [29:0] x_s1;
	logic [2:0]  oct_s1;

	logic [29:0] x_k  [NSTEP+1];
	logic [29:0] x2_k [NSTEP+1];
	logic [30:0] ts_k [NSTEP+1];
	logic [30:0] tc_k [NSTEP+1];
	logic [2:0]  oct_k [NSTEP+1];

	assign ang    = ANGLE_BITS'(heading);
	assign turn   = 32'(ang) << (32 - ANGLE_BITS);
	assign oct_in = turn[31:29];
	assign r_in   = oct_in[0] ? (OCT_SPAN - {1'b0, turn[28:0]}) : {1'b0, turn[28:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= 30'((62'(r_in) * 62'(PI_Q30)) >> 31);
			oct_s1 <= oct_in;
			x_k[0]   <= x_s1;
			x2_k[0]  <= 30'((60'(x_s1) * 60'(x_s1)) >> 30);
			ts_k[0]  <= Q30_ONE;
			tc_k[0]  <= Q30_ONE;
			oct_k[0] <= oct_s1;
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam bit LAST = (k == NSTEP - 1);
		localparam int DS = SIN_DIV[k];
		localparam int DC = COS_DIV[k];
		localparam longint unsigned MS = 64'h1_0000_0000 / DS;
		localparam longint unsigned MC = 64'h1_0000_0000 / DC;

		logic [29:0] as_k;
		logic [29:0] pa_s_s1, pa_c_s1, xa_s1, x2a_s1;
		logic [2:0]  octa_s1;
		logic [29:0] pb_s_s2, pb_c_s2, qb_s_s2, qb_c_s2, xb_s2, x2b_s2;
		logic [2:0]  octb_s2;
		logic [29:0] rs, rc, qs, qc;

		// last sine step multiplies by x instead of x^2
		assign as_k = LAST ? x_k[k] : x2_k[k];

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s_s1 <= 30'((61'(as_k) * 61'(ts_k[k])) >> 30);
				pa_c_s1 <= 30'((61'(x2_k[k]) * 61'(tc_k[k])) >> 30);
				xa_s1   <= x_k[k];
				x2a_s1  <= x2_k[k];
				octa_s1 <= oct_k[k];

				qb_s_s2 <= 30'((62'(pa_s_s1) * 62'(32'(MS))) >> 32);
				qb_c_s2 <= 30'((62'(pa_c_s1) * 62'(32'(MC))) >> 32);
				pb_s_s2 <= pa_s_s1;
				pb_c_s2 <= pa_c_s1;
				xb_s2   <= xa_s1;
				x2b_s2  <= x2a_s1;
				octb_s2 <= octa_s1;
			end
		end

		// reciprocal estimate is low by at most one
		always_comb begin
			rs = pb_s_s2 - 30'(qb_s_s2 * 30'(DS));
			rc = pb_c_s2 - 30'(qb_c_s2 * 30'(DC));
			qs = (rs >= 30'(DS)) ? qb_s_s2 + 1'b1 : qb_s_s2;
			qc = (rc >= 30'(DC)) ? qb_c_s2 + 1'b1 : qb_c_s2;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ts_k[k+1]  <= LAST ? {1'b0, pb_s_s2} : Q30_ONE - {1'b0, qs};
				tc_k[k+1]  <= Q30_ONE - {1'b0, qc};
				x_k[k+1]   <= xb_s2;
				x2_k[k+1]  <= x2b_s2;
				oct_k[k+1] <= octb_s2;
			end
		end
	end

	function automatic logic [F-1:0] rnd_sat(input logic [30:0] m);
		logic [31:0] r;
		r = (32'(m) + (32'd1 << (SH - 1))) >> SH;
		if (r > LIM) begin
			r = LIM;
		end
		return F'(r);
	endfunction

	logic [2:0] oct_o;
	logic swap, ssg, csg;
	logic [F-1:0] sm, cm;

	assign oct_o = oct_k[NSTEP];
	assign swap  = oct_o[1] ^ oct_o[0];
	assign ssg   = oct_o[2];
	assign csg   = oct_o[2] ^ oct_o[1];
	assign sm    = rnd_sat(swap ? tc_k[NSTEP] : ts_k[NSTEP]);
	assign cm    = rnd_sat(swap ? ts_k[NSTEP] : tc_k[NSTEP]);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_o <= ssg ? -$signed({1'b0, sm}) : $signed({1'b0, sm});
			cos_o <= csg ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
		end
	end
endmodule

### design/mwsm_front.sv
// front part: heading rotation, wheel mix, largest magnitude and scale decision
// depends on mwsm_pkg and mwsm_trig
module mwsm_front
	import mwsm_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic signed [IN_W-1:0]           vel_x,
	input  logic signed [IN_W-1:0]           vel_y,
	input  logic signed [IN_W-1:0]           spin_rate,
	input  logic [IN_W-1:0]                  heading,
	input  logic [CFG_W-1:0]                 max_speed,
	output logic                             q_push,
	input  logic                             q_full,
	output logic [TRIG_FRAC_BITS+17:0]       mag_o [4],
	output logic [3:0]                       neg_o,
	output logic [TRIG_FRAC_BITS+17:0]       largest_o,
	output logic                             scaled_o
);
	localparam int F  = TRIG_FRAC_BITS;
	localparam int PW = F + 17;
	localparam int SW = F + 18;
	localparam int WW = F + 19;
	localparam int MW = F + 18;

	logic [FRONT_LAT-1:0] v_q;
	logic en;

	logic signed [IN_W-1:0] vx_d [TRIG_LAT];
	logic signed [IN_W-1:0] vy_d [TRIG_LAT];
	logic signed [IN_W-1:0] om_d [TRIG_LAT];
	logic signed [F:0] s_t, c_t;

	assign en     = ~v_q[FRONT_LAT-1] | ~q_full;
	assign full   = ~en;
	assign q_push = v_q[FRONT_LAT-1] & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[FRONT_LAT-2:0], push};
		end
	end

	mwsm_trig #(
		.ANGLE_BITS(ANGLE_BITS),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_trig (
		.clk(clk),
		.en(en),
		.heading(heading),
		.sin_o(s_t),
		.cos_o(c_t)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			vx_d[0] <= vel_x;
			vy_d[0] <= vel_y;
			om_d[0] <= spin_rate;
			for (int i = 1; i < TRIG_LAT; i++) begin
				vx_d[i] <= vx_d[i-1];
				vy_d[i] <= vy_d[i-1];
				om_d[i] <= om_d[i-1];
			end
		end
	end

	logic signed [PW-1:0] pyc_s1, pxs_s1, pxc_s1, pys_s1;
	logic signed [IN_W-1:0] om_s1, om_s2;
	logic signed [SW-1:0] fwd_s2, lat_s2;
	logic signed [WW-1:0] w [4];
	logic [MW-1:0] mag_s3 [4];
	logic [3:0] neg_s3;
	logic [MW-1:0] m01, m23, lg;

	always_comb begin
		w[0] = -WW'(fwd_s2) + WW'(lat_s2) + (WW'(om_s2) <<< F);
		w[1] =  WW'(fwd_s2) + WW'(lat_s2) + (WW'(om_s2) <<< F);
		w[2] =  WW'(fwd_s2) - WW'(lat_s2) + (WW'(om_s2) <<< F);
		w[3] = -WW'(fwd_s2) - WW'(lat_s2) + (WW'(om_s2) <<< F);
	end

	assign m01 = (mag_s3[0] > mag_s3[1]) ? mag_s3[0] : mag_s3[1];
	assign m23 = (mag_s3[2] > mag_s3[3]) ? mag_s3[2] : mag_s3[3];
	assign lg  = (m01 > m23) ? m01 : m23;

	always_ff @(posedge clk) begin
		if (en) begin
			pyc_s1 <= PW'(vy_d[TRIG_LAT-1]) * PW'(c_t);
			pxs_s1 <= PW'(vx_d[TRIG_LAT-1]) * PW'(s_t);
			pxc_s1 <= PW'(vx_d[TRIG_LAT-1]) * PW'(c_t);
			pys_s1 <= PW'(vy_d[TRIG_LAT-1]) * PW'(s_t);
			om_s1  <= om_d[TRIG_LAT-1];

			fwd_s2 <= SW'(pyc_s1) + SW'(pxs_s1);
			lat_s2 <= SW'(pxc_s1) - SW'(pys_s1);
			om_s2  <= om_s1;

			for (int k = 0; k < 4; k++) begin
				mag_s3[k] <= MW'(w[k][WW-1] ? -w[k] : w[k]);
				neg_s3[k] <= w[k][WW-1];
			end

			mag_o     <= mag_s3;
			neg_o     <= neg_s3;
			largest_o <= lg;
			scaled_o  <= (lg > (MW'(max_speed) << F));
		end
	end
endmodule

### design/mwsm_back.sv
// back part: proportional scaling by a pipelined restoring divider, sign restore
// depends on mwsm_pkg
module mwsm_back
	import mwsm_pkg::*;
#(
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_pop,
	input  logic [TRIG_FRAC_BITS+17:0]       mag_i [4],
	input  logic [3:0]                       neg_i,
	input  logic [TRIG_FRAC_BITS+17:0]       largest_i,
	input  logic                             scaled_i,
	input  logic [CFG_W-1:0]                 max_speed,
	output logic                             out_push,
	input  logic                             out_full,
	output logic [OUT_W-1:0]                 wheel_o [4],
	output logic                             scaled_o
);
	localparam int F  = TRIG_FRAC_BITS;
	localparam int MW = F + 18;
	localparam int NW = MW + CFG_W;

	logic [BACK_LAT-1:0] v_q;
	logic en;

	logic [NW-1:0]     rem   [QUOT_W+1][4];
	logic [QUOT_W-1:0] quo   [QUOT_W+1][4];
	logic [MW-1:0]     lg    [QUOT_W+1];
	logic [3:0]        neg   [QUOT_W+1];
	logic              sc    [QUOT_W+1];
	logic [OUT_W-1:0]  ures  [QUOT_W+1][4];

	assign en       = ~v_q[BACK_LAT-1] | ~out_full;
	assign in_pop   = en & in_valid;
	assign out_push = v_q[BACK_LAT-1] & ~out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[BACK_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				rem[0][k]  <= NW'(mag_i[k]) * NW'(max_speed);
				quo[0][k]  <= '0;
				ures[0][k] <= OUT_W'(mag_i[k] >> F);
			end
			lg[0]  <= largest_i;
			neg[0] <= neg_i;
			sc[0]  <= scaled_i;
		end
	end

	// one quotient bit per stage, msb first; quotient fits since mag <= largest
	for (genvar i = 0; i < QUOT_W; i++) begin : g_div
		localparam int B = QUOT_W - 1 - i;
		logic [NW-1:0] dv;
		assign dv = NW'(lg[i]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 4; k++) begin
					if (rem[i][k] >= dv) begin
						rem[i+1][k] <= rem[i][k] - dv;
						quo[i+1][k] <= {quo[i][k][QUOT_W-2:0], 1'b1};
					end else begin
						rem[i+1][k] <= rem[i][k];
						quo[i+1][k] <= {quo[i][k][QUOT_W-2:0], 1'b0};
					end
					ures[i+1][k] <= ures[i][k];
				end
				lg[i+1]  <= lg[i];
				neg[i+1] <= neg[i];
				sc[i+1]  <= sc[i];
			end
		end
	end

	logic [OUT_W-1:0] m [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			m[k] = sc[QUOT_W] ? OUT_W'(quo[QUOT_W][k]) : ures[QUOT_W][k];
			wheel_o[k] = neg[QUOT_W][k] ? -m[k] : m[k];
		end
	end
	assign scaled_o = sc[QUOT_W];
endmodule

### design/mecanum_wheel_speed_mixer_top.sv
// mecanum wheel speed mixer: front pipeline, request queue, divider back end, result queue
// throughput: one request per cycle while the consumer keeps popping results,
// set by the fully pipelined trig and divider
// the front (25 stages) and back (16 stages) each stall on their own queue filling
// reset: all valid bits and queue pointers clear, the speed limit register returns to 660
// depends on mwsm_pkg, mwsm_front, mwsm_trig, mwsm_back, mwsm_fifo
module mecanum_wheel_speed_mixer_top
	import mwsm_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [IN_W-1:0]  vel_x,
	input  logic signed [IN_W-1:0]  vel_y,
	input  logic signed [IN_W-1:0]  spin_rate,
	input  logic [IN_W-1:0]         heading,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [OUT_W-1:0] wheel_front_right,
	output logic signed [OUT_W-1:0] wheel_front_left,
	output logic signed [OUT_W-1:0] wheel_rear_left,
	output logic signed [OUT_W-1:0] wheel_rear_right,
	output logic                    was_scaled,
	input  logic                    cfg_we,
	input  logic [CFG_W-1:0]        cfg_wdata
);
	localparam int MW = TRIG_FRAC_BITS + 18;
	localparam int QW = 4 * MW + 4 + MW + 1;
	localparam int RW = 4 * OUT_W + 1;

	// speed limit register; user must write only while the block is idle, unchecked here
	logic [CFG_W-1:0] max_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_SPEED_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// front side: rotate, mix, classify as scaled or not
	logic f_push, mq_full, mq_empty, b_pop;
	logic [MW-1:0] f_mag [4];
	logic [3:0] f_neg;
	logic [MW-1:0] f_lg;
	logic f_sc;

	mwsm_front #(
		.ANGLE_BITS(ANGLE_BITS),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.spin_rate(spin_rate),
		.heading(heading),
		.max_speed(max_q),
		.q_push(f_push),
		.q_full(mq_full),
		.mag_o(f_mag),
		.neg_o(f_neg),
		.largest_o(f_lg),
		.scaled_o(f_sc)
	);

	// queue between front and back
	logic [QW-1:0] mq_din, mq_dout;
	assign mq_din = {f_sc, f_lg, f_neg, f_mag[3], f_mag[2], f_mag[1], f_mag[0]};

	mwsm_fifo #(
		.W(QW),
		.DEPTH(4)
	) u_midq (
		.clk(clk),
		.arst_n(arst_n),
		.wr(f_push),
		.din(mq_din),
		.full(mq_full),
		.rd(b_pop),
		.dout(mq_dout),
		.empty(mq_empty)
	);

	logic [MW-1:0] b_mag [4];
	logic [3:0] b_neg;
	logic [MW-1:0] b_lg;
	logic b_sc;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			b_mag[k] = mq_dout[k*MW +: MW];
		end
		b_neg = mq_dout[4*MW +: 4];
		b_lg  = mq_dout[4*MW+4 +: MW];
		b_sc  = mq_dout[QW-1];
	end

	// back side: proportional scaling and sign restore
	logic b_push, oq_full;
	logic [OUT_W-1:0] b_wheel [4];
	logic b_scaled;

	mwsm_back #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(~mq_empty),
		.in_pop(b_pop),
		.mag_i(b_mag),
		.neg_i(b_neg),
		.largest_i(b_lg),
		.scaled_i(b_sc),
		.max_speed(max_q),
		.out_push(b_push),
		.out_full(oq_full),
		.wheel_o(b_wheel),
		.scaled_o(b_scaled)
	);

	// result queue, parts the back pipeline from the consumer
	logic [RW-1:0] oq_din, oq_dout;
	assign oq_din = {b_scaled, b_wheel[3], b_wheel[2], b_wheel[1], b_wheel[0]};

	mwsm_fifo #(
		.W(RW),
		.DEPTH(2)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.wr(b_push),
		.din(oq_din),
		.full(oq_full),
		.rd(pop),
		.dout(oq_dout),
		.empty(empty)
	);

	assign wheel_front_right = oq_dout[0*OUT_W +: OUT_W];
	assign wheel_front_left  = oq_dout[1*OUT_W +: OUT_W];
	assign wheel_rear_left   = oq_dout[2*OUT_W +: OUT_W];
	assign wheel_rear_right  = oq_dout[3*OUT_W +: OUT_W];
	assign was_scaled        = oq_dout[RW-1];

	// no request is ever dropped into a full queue
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !mq_full)
		else $error("front pushed into full mid queue");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		b_push |-> !oq_full)
		else $error("back pushed into full result queue");

	a_mid_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		b_pop |-> !mq_empty)
		else $error("back popped empty mid queue");
endmodule
